>>> hw/rtl/nearest_object_in_frustum_core_defines.svh
// assertion macros for the nearest object in frustum core
`ifndef NEAREST_OBJECT_IN_FRUSTUM_CORE_DEFINES_SVH
`define NEAREST_OBJECT_IN_FRUSTUM_CORE_DEFINES_SVH

// property checked outside reset
`define NOF_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// property checked on every edge, reset included
`define NOF_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

>>> hw/rtl/nof_pkg.sv
// shared types and constants for the nearest object in frustum core
`timescale 1ns / 1ps

package nof_pkg;

   localparam int COORD_BITS    = 20;
   localparam int TAG_BITS      = 16;
   localparam int RAD_BITS      = 19;
   localparam int DIST_BITS     = 19;
   localparam int ROT_BITS      = 16;
   localparam int ROT_ROW_BITS  = 3 * ROT_BITS;
   localparam int ORG_BITS      = 20;
   localparam int ORG_ALL_BITS  = 3 * ORG_BITS;
   localparam int TAN_BITS      = 18;
   localparam int FRAC_ROT      = 14;
   localparam int CSR_IDX_BITS  = 3;
   localparam int CSR_DATA_BITS = 60;

   // derived datapath widths
   localparam int DW      = ((COORD_BITS > ORG_BITS) ? COORD_BITS : ORG_BITS) + 1;
   localparam int DSQ_W   = (2 * DW + 2 > 64) ? 64 : 2 * DW + 2;
   localparam int RSQ_W   = 2 * RAD_BITS;
   localparam int CMP_W   = DSQ_W + 1;
   localparam int ACC_W   = DW + ROT_BITS + 3;
   localparam int REL_W   = ACC_W - FRAC_ROT;
   localparam int LAT_W   = TAN_BITS + REL_W - 1;
   localparam int EXC_W   = REL_W + FRAC_ROT;
   localparam int LCMP_W  = (LAT_W > EXC_W) ? LAT_W : EXC_W;
   localparam int RW      = (DSQ_W + 1) / 2;
   localparam int SQ_W    = 2 * RW;
   localparam int REM_W   = RW + 3;
   localparam int CNT_W   = $clog2(RW);

   localparam logic [DIST_BITS-1:0] DIST_SAT      = {DIST_BITS{1'b1}};
   localparam logic [DIST_BITS-1:0] MAX_RANGE_RST = DIST_BITS'(1024);
   localparam logic [DIST_BITS-1:0] MIN_RANGE_RST = '0;
   localparam logic [TAN_BITS-1:0]  TAN_RST       = TAN_BITS'(16384);

   typedef enum logic [1:0] {
      CMD_START = 2'd0,
      CMD_CAND  = 2'd1,
      CMD_END   = 2'd2,
      CMD_NONE  = 2'd3
   } cmd_type;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_ROT_X     = 3'd0,
      CSR_ROT_Y     = 3'd1,
      CSR_ROT_Z     = 3'd2,
      CSR_ORIGIN    = 3'd3,
      CSR_TAN_W     = 3'd4,
      CSR_TAN_H     = 3'd5,
      CSR_MIN_RANGE = 3'd6,
      CSR_MAX_RANGE = 3'd7
   } csr_idx_type;

   typedef struct packed {
      cmd_type                       cmd;
      logic signed [COORD_BITS-1:0]  obj_x;
      logic signed [COORD_BITS-1:0]  obj_y;
      logic signed [COORD_BITS-1:0]  obj_z;
      logic [RAD_BITS-1:0]           obj_radius;
      logic [TAG_BITS-1:0]           obj_tag;
   } req_type;

   typedef struct packed {
      logic [DIST_BITS-1:0] distance;
      logic                 hit;
      logic [TAG_BITS-1:0]  nearest_tag;
   } rsp_type;

   // controller to datapath commands
   typedef struct packed {
      logic       clr_store;
      logic       ld_cand;
      logic       mac_en;
      logic [1:0] mac_idx;
      logic       rnd_en;
      logic       lat_en;
      logic       dec_en;
      logic       root_start;
      logic       root_en;
      logic       out_load;
   } ctl_type;

endpackage

>>> hw/rtl/nof_ctrl.sv
// sequencing controller for the nearest object in frustum core
`timescale 1ns / 1ps

module nof_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  nof_pkg::cmd_type  req_cmd,
   output logic              req_stall,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output nof_pkg::ctl_type  ctl
);
   import nof_pkg::*;

   typedef enum logic [6:0] {
      ST_IDLE = 7'b0000001,
      ST_MAC  = 7'b0000010,
      ST_RND  = 7'b0000100,
      ST_LAT  = 7'b0001000,
      ST_DEC  = 7'b0010000,
      ST_ROOT = 7'b0100000,
      ST_OUT  = 7'b1000000
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             take;
   logic             out_free;

   assign take      = (state_ff == ST_IDLE) && req_valid;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // command decode
   always_comb begin
      ctl            = '0;
      ctl.clr_store  = take && (req_cmd == CMD_START);
      ctl.ld_cand    = take && (req_cmd == CMD_CAND);
      ctl.root_start = take && (req_cmd == CMD_END);
      ctl.mac_en     = (state_ff == ST_MAC);
      ctl.mac_idx    = cnt_ff[1:0];
      ctl.rnd_en     = (state_ff == ST_RND);
      ctl.lat_en     = (state_ff == ST_LAT);
      ctl.dec_en     = (state_ff == ST_DEC);
      ctl.root_en    = (state_ff == ST_ROOT);
      ctl.out_load   = (state_ff == ST_OUT) && out_free;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            cnt_in = '0;
            if (take) begin
               unique case (req_cmd)
                  CMD_CAND: state_in = ST_MAC;
                  CMD_END:  state_in = ST_ROOT;
                  default:  state_in = ST_IDLE;
               endcase
            end
         end
         ST_MAC: begin
            if (cnt_ff == CNT_W'(2)) begin
               cnt_in   = '0;
               state_in = ST_RND;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         ST_RND:  state_in = ST_LAT;
         ST_LAT:  state_in = ST_DEC;
         ST_DEC:  state_in = ST_IDLE;
         ST_ROOT: begin
            if (cnt_ff == CNT_W'(RW - 1)) begin
               cnt_in   = '0;
               state_in = ST_OUT;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         ST_OUT: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // result valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (ctl.out_load) rsp_valid_in = 1'b1;
      else if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

>>> hw/rtl/nof_dp.sv
// datapath: registers, shared multipliers, store and square root
`timescale 1ns / 1ps

module nof_dp (
   input  logic                               clock,
   input  logic                               reset,
   input  nof_pkg::ctl_type                   ctl,
   input  nof_pkg::req_type                   req_data,
   input  logic                               csr_we,
   input  logic [nof_pkg::CSR_IDX_BITS-1:0]   csr_index,
   input  logic [nof_pkg::CSR_DATA_BITS-1:0]  csr_wdata,
   output nof_pkg::rsp_type                   rsp_data
);
   import nof_pkg::*;

   // configuration
   logic [ROT_ROW_BITS-1:0] rot_ff [3];
   logic [ORG_ALL_BITS-1:0] origin_ff;
   logic [TAN_BITS-1:0]     tan_w_ff, tan_h_ff;
   logic [DIST_BITS-1:0]    min_ff, max_ff;

   // candidate work registers
   logic signed [DW-1:0]    d_ff [3];
   logic [RAD_BITS-1:0]     rad_ff;
   logic [RSQ_W-1:0]        rsq_ff;
   logic [TAG_BITS-1:0]     tag_ff;
   logic [DSQ_W-1:0]        dsq_ff;
   logic signed [ACC_W-1:0] acc_ff [3];
   logic signed [REL_W-1:0] rel_ff [3];
   logic                    score_ok_ff;
   logic                    ahead_ok_ff;
   logic [LAT_W-1:0]        lim_w_ff, lim_h_ff;
   logic [REL_W-1:0]        exc_w_ff, exc_h_ff;

   // best-candidate store
   logic [DSQ_W-1:0]        best_dsq_ff;
   logic [RSQ_W-1:0]        best_rsq_ff;
   logic [RAD_BITS-1:0]     best_rad_ff;
   logic [TAG_BITS-1:0]     best_id_ff;
   logic                    found_ff;

   // square root
   logic [SQ_W-1:0]         sqv_ff;
   logic [REM_W-1:0]        rem_ff;
   logic [RW-1:0]           root_ff;

   rsp_type                 rsp_ff;

   // combinational nets
   logic signed [COORD_BITS-1:0]       pos [3];
   logic signed [DW-1:0]               d_new [3];
   logic signed [DW-1:0]               d_sel;
   logic signed [2*DW-1:0]             sq;
   logic signed [ROT_BITS+DW-1:0]      prod [3];
   logic signed [ACC_W-1:0]            rnd_sum [3];
   logic [CMP_W-1:0]                   lhs, rhs;
   logic [REL_W-2:0]                   ahead_u;
   logic [REL_W-1:0]                   mag_w, mag_h;
   logic signed [REL_W:0]              ex_w, ex_h;
   logic [LCMP_W-1:0]                  shw, shh;
   logic                               keep;
   logic [REM_W-1:0]                   rem_sh, trial;
   logic [RW-1:0]                      diff, dist_full;
   logic [DIST_BITS-1:0]               dist_clip;

   assign pos[0] = req_data.obj_x;
   assign pos[1] = req_data.obj_y;
   assign pos[2] = req_data.obj_z;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         rot_ff[0] <= '0;
         rot_ff[1] <= '0;
         rot_ff[2] <= '0;
         origin_ff <= '0;
         tan_w_ff  <= TAN_RST;
         tan_h_ff  <= TAN_RST;
         min_ff    <= MIN_RANGE_RST;
         max_ff    <= MAX_RANGE_RST;
      end else if (csr_we) begin
         unique case (csr_idx_type'(csr_index))
            CSR_ROT_X:     rot_ff[0] <= csr_wdata[ROT_ROW_BITS-1:0];
            CSR_ROT_Y:     rot_ff[1] <= csr_wdata[ROT_ROW_BITS-1:0];
            CSR_ROT_Z:     rot_ff[2] <= csr_wdata[ROT_ROW_BITS-1:0];
            CSR_ORIGIN:    origin_ff <= csr_wdata[ORG_ALL_BITS-1:0];
            CSR_TAN_W:     tan_w_ff  <= csr_wdata[TAN_BITS-1:0];
            CSR_TAN_H:     tan_h_ff  <= csr_wdata[TAN_BITS-1:0];
            CSR_MIN_RANGE: min_ff    <= csr_wdata[DIST_BITS-1:0];
            CSR_MAX_RANGE: max_ff    <= csr_wdata[DIST_BITS-1:0];
            default: ;
         endcase
      end
   end

   // offsets from the sensor origin
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         d_new[k] = DW'(pos[k])
                  - DW'($signed(origin_ff[k*ORG_BITS +: ORG_BITS]));
      end
   end

   // shared multiply-accumulate, one column per cycle
   always_comb begin
      d_sel = d_ff[ctl.mac_idx];
      sq    = d_sel * d_sel;
      for (int i = 0; i < 3; i++) begin
         prod[i] = $signed(rot_ff[i][ctl.mac_idx*ROT_BITS +: ROT_BITS]) * d_sel;
      end
   end

   // score compare and rounding from Q14 to integer
   always_comb begin
      lhs = CMP_W'(dsq_ff) + CMP_W'(best_rsq_ff);
      rhs = CMP_W'(best_dsq_ff) + CMP_W'(rsq_ff);
      for (int i = 0; i < 3; i++) begin
         rnd_sum[i] = acc_ff[i] + ACC_W'(1 << (FRAC_ROT - 1));
      end
   end

   // lateral excess beyond the radius
   always_comb begin
      ahead_u = rel_ff[0][REL_W-2:0];
      mag_w   = rel_ff[1][REL_W-1] ? REL_W'(-rel_ff[1]) : REL_W'(rel_ff[1]);
      mag_h   = rel_ff[2][REL_W-1] ? REL_W'(-rel_ff[2]) : REL_W'(rel_ff[2]);
      ex_w    = $signed({1'b0, mag_w}) - $signed((REL_W+1)'(rad_ff));
      ex_h    = $signed({1'b0, mag_h}) - $signed((REL_W+1)'(rad_ff));
   end

   // keep decision
   always_comb begin
      shw  = LCMP_W'({exc_w_ff, {FRAC_ROT{1'b0}}});
      shh  = LCMP_W'({exc_h_ff, {FRAC_ROT{1'b0}}});
      keep = score_ok_ff && ahead_ok_ff
          && (shw < LCMP_W'(lim_w_ff)) && (shh < LCMP_W'(lim_h_ff));
   end

   always_ff @(posedge clock) begin
      if (ctl.ld_cand) begin
         for (int k = 0; k < 3; k++) begin
            d_ff[k]   <= d_new[k];
            acc_ff[k] <= '0;
         end
         rad_ff <= req_data.obj_radius;
         rsq_ff <= req_data.obj_radius * req_data.obj_radius;
         tag_ff <= req_data.obj_tag;
         dsq_ff <= '0;
      end else if (ctl.mac_en) begin
         dsq_ff <= dsq_ff + DSQ_W'(unsigned'(sq));
         for (int i = 0; i < 3; i++) begin
            acc_ff[i] <= acc_ff[i] + ACC_W'(prod[i]);
         end
      end
      if (ctl.rnd_en) begin
         score_ok_ff <= (lhs < rhs);
         for (int i = 0; i < 3; i++) begin
            rel_ff[i] <= rnd_sum[i][ACC_W-1:FRAC_ROT];
         end
      end
      if (ctl.lat_en) begin
         ahead_ok_ff <= (rel_ff[0] > 0);
         lim_w_ff    <= tan_w_ff * ahead_u;
         lim_h_ff    <= tan_h_ff * ahead_u;
         exc_w_ff    <= ex_w[REL_W] ? '0 : ex_w[REL_W-1:0];
         exc_h_ff    <= ex_h[REL_W] ? '0 : ex_h[REL_W-1:0];
      end
   end

   // best-candidate store
   always_ff @(posedge clock) begin
      if (reset) begin
         best_dsq_ff <= DSQ_W'(MAX_RANGE_RST) * DSQ_W'(MAX_RANGE_RST);
         best_rsq_ff <= '0;
         best_rad_ff <= '0;
         best_id_ff  <= '0;
         found_ff    <= 1'b0;
      end else if (ctl.clr_store) begin
         best_dsq_ff <= DSQ_W'(max_ff) * DSQ_W'(max_ff);
         best_rsq_ff <= '0;
         best_rad_ff <= '0;
         best_id_ff  <= '0;
         found_ff    <= 1'b0;
      end else if (ctl.dec_en && keep) begin
         best_dsq_ff <= dsq_ff;
         best_rsq_ff <= rsq_ff;
         best_rad_ff <= rad_ff;
         best_id_ff  <= tag_ff;
         found_ff    <= 1'b1;
      end
   end

   // digit-by-digit square root, two radicand bits a cycle
   always_comb begin
      rem_sh = {rem_ff[REM_W-3:0], sqv_ff[SQ_W-1 -: 2]};
      trial  = REM_W'({root_ff, 2'b01});
   end

   always_ff @(posedge clock) begin
      if (ctl.root_start) begin
         sqv_ff  <= SQ_W'(best_dsq_ff);
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (ctl.root_en) begin
         sqv_ff <= {sqv_ff[SQ_W-3:0], 2'b00};
         if (rem_sh >= trial) begin
            rem_ff  <= rem_sh - trial;
            root_ff <= {root_ff[RW-2:0], 1'b1};
         end else begin
            rem_ff  <= rem_sh;
            root_ff <= {root_ff[RW-2:0], 1'b0};
         end
      end
   end

   // report distance
   always_comb begin
      diff = root_ff - RW'(best_rad_ff);
      if (!found_ff) dist_full = RW'(max_ff);
      else if ((root_ff > RW'(best_rad_ff)) && (diff > RW'(min_ff))) dist_full = diff;
      else dist_full = RW'(min_ff);
      dist_clip = (dist_full > RW'(DIST_SAT)) ? DIST_SAT : dist_full[DIST_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (ctl.out_load) begin
         rsp_ff.distance    <= dist_clip;
         rsp_ff.hit         <= found_ff;
         rsp_ff.nearest_tag <= found_ff ? best_id_ff : '0;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

>>> hw/rtl/nearest_object_in_frustum_core.sv
// top level: nearest sphere in the sensor frustum, scan engine
// a start or unused command beat leaves the controller idle; a candidate beat runs
// to the end before the next beat can be taken (accept, shared multiply-accumulate
// steps, one per column, then round, lateral multiply and decide); an end beat runs
// the 22-step square root, then registers its result once the output is not stalled
// synchronous active-high reset restores the register defaults and clears the store
`timescale 1ns / 1ps

module nearest_object_in_frustum_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  nof_pkg::req_type                   req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output nof_pkg::rsp_type                   rsp_data,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [nof_pkg::CSR_IDX_BITS-1:0]   csr_index,
   input  logic [nof_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);
   import nof_pkg::*;

   ctl_type ctl;

   assign csr_ready = 1'b1;

   // sequencer
   nof_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_cmd   (req_data.cmd),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .ctl       (ctl)
   );

   // arithmetic and storage
   nof_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .req_data  (req_data),
      .csr_we    (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_data  (rsp_data)
   );

endmodule

>>> hw/rtl/nof_checker.sv
// port checker for the nearest object in frustum core
`timescale 1ns / 1ps
`include "nearest_object_in_frustum_core_defines.svh"

module nof_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  nof_pkg::req_type  req_data,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  nof_pkg::rsp_type  rsp_data
);
   import nof_pkg::*;

   // a stalled result beat stays
   `NOF_ASSERT(a_rsp_hold, rsp_valid && rsp_stall |=> rsp_valid, "result beat dropped")
   // a stalled result beat keeps its payload
   `NOF_ASSERT(a_rsp_stable, rsp_valid && rsp_stall |=> $stable(rsp_data), "result changed")
   // a candidate beat keeps the input side busy afterwards
   `NOF_ASSERT(a_cand_busy, req_valid && !req_stall && req_data.cmd == CMD_CAND |=> req_stall, "candidate not sequenced")
   // no hit reports a zero tag
   `NOF_ASSERT(a_miss_tag, !(rsp_valid && !rsp_data.hit) || rsp_data.nearest_tag == '0, "tag on miss")

endmodule

bind nearest_object_in_frustum_core nof_checker u_nof_checker (.*);
